@@ hdl/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddo_pkg: shared types, constants and functions of the wheel odometry block
// Holds the register map, fixed-point constants and the CORDIC arctan table.
// ----------------------------------------------------------------------------
package ddo_pkg;

  typedef enum logic [1:0] {
    CFG_COUNT_SCALE   = 2'd0,
    CFG_INVERT_COUNTS = 2'd1,
    CFG_TURN_GAIN     = 2'd2,
    CFG_MAX_STEP      = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [31:0] RstCountScale = 32'd3024000;
  localparam logic [31:0] RstTurnGain   = 32'd1471593000;
  localparam logic [25:0] RstMaxStep    = 26'd16777216;

  // CORDIC start value, Q2.30, pre-scaled by the inverse rotation gain
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [31:0]        UsecPerSec = 32'd1000000;

  // Dividend width of the shared divider and its divisor width
  localparam int unsigned NumW = 52;
  localparam int unsigned DenW = 21;

  localparam int unsigned InDataW  = 216;
  localparam int unsigned OutDataW = 264;

  // Arctangent of 2^-i in binary-angle units (2^32 per turn)
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Signed 41-bit result from a sign and an unsigned quotient, saturating
  function automatic logic [40:0] sat41(input logic neg, input logic [NumW-1:0] q);
    logic [40:0] r;
    if (!neg) begin
      r = (q >= (NumW'(1) << 40)) ? {1'b0, {40{1'b1}}} : q[40:0];
    end else begin
      r = (q > (NumW'(1) << 40)) ? {1'b1, 40'd0} : (41'd0 - q[40:0]);
    end
    return r;
  endfunction

endpackage

@@ hdl/differential_drive_odometry_top.sv @@
// A wheel sample's processing is dominated by two 52-step divider passes;
// the CORDIC runs beside the first one.
// A pose set item is taken while idle and gives no result.
// Throughput: one item at a time; s_axis_tready is high only while idle.
// A finished result waits in the output register; the next one stalls only behind it.
// Reset (rst_ni low, asynchronous) clears the pose, stored counts and registers to defaults.
// ----------------------------------------------------------------------------
// differential_drive_odometry_top: fixed-point wheel odometry
// Turns accumulated wheel counts into steps, heading, position, speed and
// heading rate, using one shared multiplier, one divider and a CORDIC.
// ----------------------------------------------------------------------------
module differential_drive_odometry_top #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ddo_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ddo_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // left_count, right_count, elapsed_us, set_x, set_y, set_heading, zero pad
  input  logic [ddo_pkg::InDataW-1:0]      s_axis_tdata,
  // cmd
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pos_x, pos_y, heading, left_step, right_step, speed, heading_rate
  output logic [ddo_pkg::OutDataW-1:0]     m_axis_tdata,
  // step_rejected
  output logic                             m_axis_tuser
);
  import ddo_pkg::*;

  localparam int unsigned CntW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_L  = 4'd1;
  localparam logic [3:0] ST_MUL_R  = 4'd2;
  localparam logic [3:0] ST_REJ    = 4'd3;
  localparam logic [3:0] ST_MUL_H  = 4'd4;
  localparam logic [3:0] ST_HEAD   = 4'd5;
  localparam logic [3:0] ST_MUL_RT = 4'd6;
  localparam logic [3:0] ST_DIV_RT = 4'd7;
  localparam logic [3:0] ST_MUL_SP = 4'd8;
  localparam logic [3:0] ST_DIV_SP = 4'd9;
  localparam logic [3:0] ST_MUL_X  = 4'd10;
  localparam logic [3:0] ST_MUL_Y  = 4'd11;
  localparam logic [3:0] ST_ACC_Y  = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  // input fields
  logic [31:0] in_left, in_right, in_head;
  logic [19:0] in_elapsed;
  logic [47:0] in_x, in_y;
  assign in_left    = s_axis_tdata[31:0];
  assign in_right   = s_axis_tdata[63:32];
  assign in_elapsed = s_axis_tdata[83:64];
  assign in_x       = s_axis_tdata[131:84];
  assign in_y       = s_axis_tdata[179:132];
  assign in_head    = s_axis_tdata[211:180];

  // configuration
  logic [31:0] count_scale_q, turn_gain_q;
  logic        invert_q;
  logic [25:0] max_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_scale_q <= RstCountScale;
      invert_q      <= 1'b0;
      turn_gain_q   <= RstTurnGain;
      max_step_q    <= RstMaxStep;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COUNT_SCALE:   count_scale_q <= cfg_data_i;
        CFG_INVERT_COUNTS: invert_q      <= cfg_data_i[0];
        CFG_TURN_GAIN:     turn_gain_q   <= cfg_data_i;
        CFG_MAX_STEP:      max_step_q    <= cfg_data_i[25:0];
        default: ;
      endcase
    end
  end

  // state
  logic [3:0]  state_q;
  logic        started_q;
  logic [31:0] prev_left_q, prev_right_q, heading_q, prev_heading_q;
  logic [47:0] x_q, y_q;
  logic [31:0] dl_mag_q, dr_mag_q;
  logic        dl_neg_q, dr_neg_q;
  logic [19:0] e_q;
  logic        rej_q;
  logic [26:0] left_q, right_q;
  logic [27:0] sum_q;
  logic        diff_neg_q, dh_neg_q;
  logic [40:0] rate_q, speed_q;
  logic [63:0] prod_q;
  logic        out_valid_q, out_rej_q;
  logic [OutDataW-1:0] out_data_q;

  // divider
  logic            dv_run_q;
  logic [NumW-1:0] dv_num_q;
  logic [DenW-1:0] dv_rem_q, dv_den_q;
  logic [5:0]      dv_cnt_q;

  // CORDIC
  logic                   cd_run_q, cd_flip_q;
  logic [CntW-1:0]        cd_cnt_q;
  logic signed [33:0]     cd_x_q, cd_y_q, cd_z_q;

  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // counts and deltas at acceptance
  logic [31:0] lc, rc, dl, dr;
  always_comb begin
    lc = invert_q ? (32'd0 - in_left)  : in_left;
    rc = invert_q ? (32'd0 - in_right) : in_right;
    dl = started_q ? (lc - prev_left_q)  : 32'd0;
    dr = started_q ? (rc - prev_right_q) : 32'd0;
  end

  // wheel distance magnitude from the product, rounded
  logic [63:0] rnd8;
  logic [55:0] mstep;
  logic        step_big;
  assign rnd8     = prod_q + 64'd128;
  assign mstep    = rnd8[63:8];
  assign step_big = mstep > {30'd0, max_step_q};

  logic [27:0] diff;
  logic [27:0] diff_mag, sum_mag;
  assign diff     = {right_q[26], right_q} - {left_q[26], left_q};
  assign diff_mag = diff[27] ? (28'd0 - diff) : diff;
  assign sum_mag  = sum_q[27] ? (28'd0 - sum_q) : sum_q;

  logic [63:0] rnd24;
  logic [31:0] dh_mag;
  assign rnd24  = prod_q + (64'd1 << 23);
  assign dh_mag = rnd24[55:24];

  logic [31:0] dhead, dhead_mag;
  assign dhead     = heading_q - prev_heading_q;
  assign dhead_mag = dhead[31] ? (32'd0 - dhead) : dhead;

  logic [33:0] cx_mag, cy_mag;
  assign cx_mag = cd_x_q[33] ? (34'd0 - cd_x_q) : cd_x_q;
  assign cy_mag = cd_y_q[33] ? (34'd0 - cd_y_q) : cd_y_q;

  // position step, rounded by 2^31, then saturating accumulation
  logic [63:0] rnd31;
  logic [27:0] pstep;
  logic        pneg;
  logic [47:0] acc_src, acc_new;
  logic [48:0] acc_sum;
  always_comb begin
    rnd31   = prod_q + (64'd1 << 30);
    pstep   = rnd31[58:31];
    pneg    = (state_q == ST_MUL_Y) ? (sum_q[27] ^ cd_x_q[33] ^ cd_flip_q)
                                    : (sum_q[27] ^ cd_y_q[33] ^ cd_flip_q);
    acc_src = (state_q == ST_MUL_Y) ? x_q : y_q;
    acc_sum = pneg ? ({acc_src[47], acc_src} - {21'd0, pstep})
                   : ({acc_src[47], acc_src} + {21'd0, pstep});
    if (acc_sum[48] != acc_sum[47]) begin
      acc_new = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      acc_new = acc_sum[47:0];
    end
  end

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  always_comb begin
    unique case (state_q)
      ST_MUL_L:  begin mul_a = dl_mag_q;               mul_b = count_scale_q; end
      ST_MUL_R:  begin mul_a = dr_mag_q;               mul_b = count_scale_q; end
      ST_MUL_H:  begin mul_a = {4'd0, diff_mag};       mul_b = turn_gain_q;   end
      ST_MUL_RT: begin mul_a = dhead_mag;              mul_b = UsecPerSec;    end
      ST_MUL_SP: begin mul_a = {4'd0, sum_mag};        mul_b = UsecPerSec;    end
      ST_MUL_X:  begin mul_a = {4'd0, sum_mag};        mul_b = cx_mag[31:0];  end
      ST_MUL_Y:  begin mul_a = {4'd0, sum_mag};        mul_b = cy_mag[31:0];  end
      default:   begin mul_a = 32'd0;                  mul_b = 32'd0;         end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // divider step
  logic [DenW:0]   dv_t;
  logic            dv_ge;
  logic [DenW-1:0] dv_rem_d;
  logic [NumW-1:0] dv_num_d;
  logic            dv_last;
  always_comb begin
    dv_t     = {dv_rem_q, dv_num_q[NumW-1]};
    dv_ge    = dv_t >= {1'b0, dv_den_q};
    dv_rem_d = dv_ge ? DenW'(dv_t - {1'b0, dv_den_q}) : dv_t[DenW-1:0];
    dv_num_d = {dv_num_q[NumW-2:0], dv_ge};
    dv_last  = (dv_cnt_q == 6'(NumW - 1));
  end

  // CORDIC step
  logic               cd_dir;
  logic signed [33:0] cd_xs, cd_ys, cd_at;
  always_comb begin
    cd_dir = !cd_z_q[33];
    cd_xs  = cd_x_q >>> cd_cnt_q;
    cd_ys  = cd_y_q >>> cd_cnt_q;
    cd_at  = $signed({4'd0, atan_lut(5'(cd_cnt_q))});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_run_q  <= 1'b0;
      cd_flip_q <= 1'b0;
      cd_cnt_q  <= '0;
    end else if (state_q == ST_MUL_RT) begin
      cd_run_q  <= 1'b1;
      cd_flip_q <= heading_q[31] ^ heading_q[30];
      cd_cnt_q  <= '0;
    end else if (cd_run_q) begin
      cd_cnt_q <= cd_cnt_q + CntW'(1);
      if (cd_cnt_q == CntW'(CORDIC_STEPS - 1)) begin
        cd_run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL_RT) begin
      // fold by half a turn into the right half plane
      cd_x_q <= CordicGain;
      cd_y_q <= '0;
      cd_z_q <= $signed({{3{heading_q[30]}}, heading_q[30:0]});
    end else if (cd_run_q) begin
      cd_x_q <= cd_dir ? (cd_x_q - cd_ys) : (cd_x_q + cd_ys);
      cd_y_q <= cd_dir ? (cd_y_q + cd_xs) : (cd_y_q - cd_xs);
      cd_z_q <= cd_dir ? (cd_z_q - cd_at) : (cd_z_q + cd_at);
    end
  end

  // sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      started_q      <= 1'b0;
      prev_left_q    <= '0;
      prev_right_q   <= '0;
      heading_q      <= '0;
      prev_heading_q <= '0;
      x_q            <= '0;
      y_q            <= '0;
      dv_run_q       <= 1'b0;
      dv_cnt_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tuser) begin
              x_q       <= in_x;
              y_q       <= in_y;
              heading_q <= in_head;
            end else begin
              started_q    <= 1'b1;
              prev_left_q  <= lc;
              prev_right_q <= rc;
              state_q      <= ST_MUL_L;
            end
          end
        end
        ST_MUL_L:  state_q <= ST_MUL_R;
        ST_MUL_R:  state_q <= ST_REJ;
        ST_REJ:    state_q <= ST_MUL_H;
        ST_MUL_H:  state_q <= ST_HEAD;
        ST_HEAD: begin
          heading_q <= dh_neg_q ? (heading_q - dh_mag) : (heading_q + dh_mag);
          state_q   <= ST_MUL_RT;
        end
        ST_MUL_RT: begin
          prev_heading_q <= heading_q;
          state_q        <= ST_DIV_RT;
        end
        ST_DIV_RT, ST_DIV_SP: begin
          if (!dv_run_q) begin
            dv_run_q <= 1'b1;
            dv_cnt_q <= '0;
          end else begin
            dv_cnt_q <= dv_cnt_q + 6'd1;
            if (dv_last) begin
              dv_run_q <= 1'b0;
              state_q  <= (state_q == ST_DIV_RT) ? ST_MUL_SP : ST_MUL_X;
            end
          end
        end
        ST_MUL_SP: state_q <= ST_DIV_SP;
        ST_MUL_X:  state_q <= ST_MUL_Y;
        ST_MUL_Y: begin
          x_q     <= acc_new;
          state_q <= ST_ACC_Y;
        end
        ST_ACC_Y: begin
          y_q     <= acc_new;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        dl_mag_q <= dl[31] ? (32'd0 - dl) : dl;
        dr_mag_q <= dr[31] ? (32'd0 - dr) : dr;
        dl_neg_q <= dl[31];
        dr_neg_q <= dr[31];
        e_q      <= (in_elapsed == 20'd0) ? 20'd1 : in_elapsed;
      end
      ST_MUL_R: begin
        // left distance takes the opposite sign of its count delta
        rej_q  <= step_big;
        left_q <= dl_neg_q ? mstep[26:0] : (27'd0 - mstep[26:0]);
      end
      ST_REJ: begin
        if (rej_q || step_big) begin
          rej_q   <= 1'b1;
          left_q  <= '0;
          right_q <= '0;
        end else begin
          right_q <= dr_neg_q ? (27'd0 - mstep[26:0]) : mstep[26:0];
        end
      end
      ST_MUL_H: begin
        dh_neg_q   <= diff[27];
        diff_neg_q <= diff[27];
        sum_q      <= {left_q[26], left_q} + {right_q[26], right_q};
      end
      ST_MUL_RT: diff_neg_q <= dhead[31];
      ST_DIV_RT, ST_DIV_SP: begin
        if (!dv_run_q) begin
          dv_rem_q <= '0;
          if (state_q == ST_DIV_RT) begin
            dv_num_q <= prod_q[NumW-1:0] + NumW'(e_q >> 1);
            dv_den_q <= DenW'(e_q);
          end else begin
            dv_num_q <= prod_q[NumW-1:0] + NumW'(e_q);
            dv_den_q <= {e_q, 1'b0};
          end
        end else begin
          dv_rem_q <= dv_rem_d;
          dv_num_q <= dv_num_d;
          if (dv_last) begin
            if (state_q == ST_DIV_RT) begin
              rate_q <= sat41(diff_neg_q, dv_num_d);
            end else begin
              speed_q <= sat41(sum_q[27], dv_num_d);
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_q <= {rate_q, speed_q, right_q, left_q, heading_q, y_q, x_q};
          out_rej_q  <= rej_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_rej_q;

`ifndef SYNTHESIS
  a_rej_zero_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[181:128] == 54'd0)
    else $error("rejected item carries nonzero wheel steps");

  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_run_q |-> (state_q == ST_DIV_RT || state_q == ST_DIV_SP))
    else $error("divider running outside a divide state");

  a_cordic_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL_X |-> !cd_run_q)
    else $error("cosine used before CORDIC finished");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside the final step");
`endif

endmodule

@@ test/tb_differential_drive_odometry_top.sv @@
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry_top: self-checking bench of the wheel odometry
// Streams wheel samples and pose sets through the block under several register
// settings, predicts every pose in a local fixed-point model and compares each
// result field by field, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_differential_drive_odometry_top;
  import ddo_pkg::*;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned CycleLimit  = 1500000;
  localparam int unsigned SettleCyc   = 200;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_POSE   = 1'b1
  } odo_cmd_e;

  // highest field first, matching {m_axis_tdata, m_axis_tuser}
  typedef struct packed {
    logic signed [40:0] heading_rate;
    logic signed [40:0] speed;
    logic signed [26:0] right_step;
    logic signed [26:0] left_step;
    logic [31:0]        heading;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_x;
    logic               step_rejected;
  } odo_pose_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  differential_drive_odometry_top #(
    .CORDIC_STEPS(CordicSteps)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // odometry model state and registers
  logic [31:0]        m_scale = RstCountScale;
  logic               m_invert = 1'b0;
  logic [31:0]        m_gain = RstTurnGain;
  logic [25:0]        m_max_step = RstMaxStep;
  logic               m_primed = 1'b0;
  logic [31:0]        m_prev_l = '0, m_prev_r = '0, m_head = '0, m_prev_head = '0;
  longint             m_x = 0, m_y = 0;

  odo_pose_t   pending_poses[$];
  int unsigned n_mismatch = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max = 12;
  logic [31:0] cur_l = '0, cur_r = '0;

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint with_sign(input longint sgn, input longint unsigned m);
    return (sgn < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_shift(input longint v, input int unsigned sh);
    return with_sign(v, (mag(v) + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic longint round_div(input longint v, input longint unsigned d);
    return with_sign(v, (mag(v) + d / 2) / d);
  endfunction

  function automatic longint clamp_bits(input longint v, input int unsigned w);
    longint lim;
    lim = longint'(1) << (w - 1);
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void heading_cos_sin(input logic [31:0] h, output longint c,
                                          output longint s);
    longint atan_q[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                           21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                           333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                           1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
    logic               flip;
    logic signed [31:0] hz;
    longint             x, y, z, nx;
    flip = (h[31:30] == 2'd1) || (h[31:30] == 2'd2);
    // fold the back half-plane onto the front one
    if (flip) h = h + 32'h8000_0000;
    hz = h;
    z = hz;
    x = 652032874;
    y = 0;
    for (int i = 0; i < CordicSteps && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_q[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_q[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  task automatic advance_odometry(input odo_cmd_e cmd, input logic [31:0] l_in, r_in,
                                  input logic [19:0] el, input logic [47:0] sx, sy,
                                  input logic [31:0] sh);
    logic [31:0]        lc, rc;
    logic signed [31:0] d32;
    longint             dl, dr, left, right, dh, rate, spd, sum, c, s;
    longint unsigned    e;
    logic               rej;
    odo_pose_t          p;
    if (cmd == CMD_POSE) begin
      m_x = longint'(signed'(sx));
      m_y = longint'(signed'(sy));
      m_head = sh;
      return;
    end
    lc = m_invert ? -l_in : l_in;
    rc = m_invert ? -r_in : r_in;
    if (!m_primed) begin
      m_primed = 1'b1;
      m_prev_l = lc;
      m_prev_r = rc;
    end
    d32 = lc - m_prev_l;
    dl = d32;
    d32 = rc - m_prev_r;
    dr = d32;
    m_prev_l = lc;
    m_prev_r = rc;
    left  = with_sign(-dl, (mag(dl) * longint'({32'd0, m_scale}) + 128) >> 8);
    right = with_sign(dr, (mag(dr) * longint'({32'd0, m_scale}) + 128) >> 8);
    rej = (mag(left) > m_max_step) || (mag(right) > m_max_step);
    if (rej) begin
      left = 0;
      right = 0;
    end
    dh = round_shift((right - left) * longint'({32'd0, m_gain}), 24);
    m_head = m_head + dh[31:0];
    e = (el == 0) ? 1 : el;
    d32 = m_head - m_prev_head;
    rate = clamp_bits(round_div(longint'(d32) * 1000000, e), 41);
    m_prev_head = m_head;
    sum = left + right;
    heading_cos_sin(m_head, c, s);
    m_x = clamp_bits(m_x + round_shift(sum * c, 31), 48);
    m_y = clamp_bits(m_y + round_shift(sum * s, 31), 48);
    spd = clamp_bits(round_div(sum * 1000000, 2 * e), 41);
    p.pos_x         = m_x[47:0];
    p.pos_y         = m_y[47:0];
    p.heading       = m_head;
    p.left_step     = left[26:0];
    p.right_step    = right[26:0];
    p.speed         = spd[40:0];
    p.heading_rate  = rate[40:0];
    p.step_rejected = rej;
    pending_poses.push_back(p);
  endtask

  // hold the item until accepted; bursts with random gaps in between
  task automatic send_item(input odo_cmd_e cmd, input logic [31:0] l, r,
                           input logic [19:0] el, input logic [47:0] sx, sy,
                           input logic [31:0] sh);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'd0, sh, sy, sx, el, r, l};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_odometry(cmd, l, r, el, sx, sy, sh);
  endtask

  task automatic send_sample(input logic [31:0] l, r, input logic [19:0] el);
    cur_l = l;
    cur_r = r;
    send_item(CMD_SAMPLE, l, r, el, 48'($urandom), 48'($urandom), $urandom);
  endtask

  task automatic send_pose(input logic [47:0] sx, sy, input logic [31:0] sh);
    send_item(CMD_POSE, $urandom, $urandom, 20'($urandom), sx, sy, sh);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [31:0] scale, input logic inv,
                               input logic [31:0] gain, input logic [25:0] mx);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_COUNT_SCALE;   cfg_data_i <= scale;       @(posedge clk_i);
    cfg_idx_i <= CFG_INVERT_COUNTS; cfg_data_i <= {31'd0, inv}; @(posedge clk_i);
    cfg_idx_i <= CFG_TURN_GAIN;     cfg_data_i <= gain;        @(posedge clk_i);
    cfg_idx_i <= CFG_MAX_STEP;      cfg_data_i <= {6'd0, mx};  @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_scale = scale;
    m_invert = inv;
    m_gain = gain;
    m_max_step = mx;
  endtask

  task automatic test_directed();
    send_sample(32'h8000_0000, 32'h7fff_ffff, 20'd1000);
    // both counts wrap across the signed boundary; zero elapsed time
    send_sample(32'h7fff_fffe, 32'h8000_0005, 20'd0);
    send_sample(cur_l - 100, cur_r + 100, 20'hfffff);
    send_sample(cur_l + 100000, cur_r, 20'd20000);
    send_pose(48'h7fff_ffff_ffff, 48'h8000_0000_0000, 32'd0);
    send_sample(cur_l - 500, cur_r + 500, 20'd1);
    send_pose(48'd0, 48'd0, 32'h4000_0000);
    send_sample(cur_l - 300, cur_r + 300, 20'd50000);
    send_pose(48'd0, 48'd0, 32'h8000_0000);
    send_sample(cur_l - 300, cur_r + 300, 20'd50000);
    send_pose(48'd0, 48'd0, 32'hc000_0000);
    send_sample(cur_l - 300, cur_r + 300, 20'd50000);
    send_pose(48'd0, 48'd0, 32'hffff_ffff);
    send_sample(cur_l + 800, cur_r + 800, 20'd1);
    send_sample(cur_l - 800, cur_r - 800, 20'd1);
    send_sample(cur_l + 700, cur_r - 700, 20'd100);
    send_sample(32'hffff_ffff, 32'h0000_0000, 20'd3);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned pick, span;
    logic [19:0] el;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 100 == 50) gap_max = (gap_max == 0) ? 12 : 0;
      if (k % 150 == 149) wait_drained();
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       el = 20'($urandom);
        1:       el = 20'($urandom_range(0, 2));
        default: el = 20'($urandom_range(1000, 100000));
      endcase
      if (pick < 8) begin
        if (pick == 0) begin
          send_pose({1'b0, {47{1'b1}}}, {1'b1, 47'd0}, $urandom);
        end else begin
          send_pose(48'({$urandom, $urandom} >> $urandom_range(0, 30)),
                    48'(-({$urandom, $urandom} >> $urandom_range(0, 30))), $urandom);
        end
      end else if (pick < 13) begin
        send_sample($urandom, $urandom, el);
      end else begin
        case ($urandom_range(0, 2))
          0:       span = 3;
          1:       span = 300;
          default: span = 3000;
        endcase
        send_sample(cur_l + $urandom_range(0, 2 * span) - span,
                    cur_r + $urandom_range(0, 2 * span) - span, el);
      end
    end
    wait_drained();
  endtask

  // receiver stall pattern: always ready, periodic, or random
  always @(posedge clk_i) begin
    case ((cycle_cnt / 700) % 3)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= (cycle_cnt % 7) >= 3;
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    odo_pose_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser};
      if (pending_poses.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected pose: %p", got);
      end else begin
        want = pending_poses.pop_front();
        if (got.pos_x != want.pos_x || got.pos_y != want.pos_y ||
            got.heading != want.heading || got.left_step != want.left_step ||
            got.right_step != want.right_step || got.speed != want.speed ||
            got.heading_rate != want.heading_rate ||
            got.step_rejected != want.step_rejected) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("pose mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(280);
    load_settings(32'hffff_ffff, 1'b1, 32'hffff_ffff, 26'd33554432);
    test_directed();
    test_random(250);
    load_settings(32'd1, 1'b0, 32'd1, 26'd0);
    test_random(150);
    load_settings(32'd3024000, 1'b1, 32'd1471593000, 26'd40000);
    test_random(150);
    load_settings($urandom_range(1, 32'hffff_ffff), 1'($urandom),
                  $urandom_range(1, 32'hffff_ffff), 26'($urandom_range(0, 33554432)));
    test_random(250);
    if (n_mismatch == 0 && pending_poses.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
